>>> design/scope_trigger_autoscale_assert.svh
// assertion macros for the scope trigger autoscale block
`ifndef SCOPE_TRIGGER_AUTOSCALE_ASSERT_SVH
`define SCOPE_TRIGGER_AUTOSCALE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define STA_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
`define STA_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) else $error("assertion failed");
`else
`define STA_ASSERT(label, prop)
`define STA_ASSERT_RST(label, prop)
`endif
`endif

>>> design/sta_pkg.sv
// shared constants and types of the scope trigger autoscale block
package sta_pkg;
   localparam int RecordLen   = 120;
   localparam int PretrigLen  = 60;
   localparam int ChartRows   = 55;
   localparam int ScreenRows  = 64;
   localparam int StoreDepth  = RecordLen + PretrigLen;
   localparam int FullScale   = 255;
   localparam int AddrW       = $clog2(StoreDepth);

   localparam logic [1:0] CSR_TRIGGER_MODE = 2'd0;
   localparam logic [1:0] CSR_GAIN_SHIFT   = 2'd1;
   localparam logic [1:0] CSR_SUPPLY       = 2'd2;

   localparam logic [1:0] MODE_RISING  = 2'd1;
   localparam logic [1:0] MODE_FALLING = 2'd2;

   localparam logic KIND_LOAD = 1'b0;

   // queue entry between front and back
   typedef struct packed {
      logic       kind;
      logic [7:0] sample;
   } cmd_type;
endpackage

>>> design/sta_front.sv
// front part: takes requests into a short queue
module sta_front import sta_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  cmd_type req_cmd,
   output logic    q_valid,
   input  logic    q_take,
   output cmd_type q_cmd
);
   cmd_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_cmd     = mem_ff[rp_ff];

   // pointer and count update
   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ (q_take && q_valid);
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_take && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= req_cmd;
   end
endmodule

>>> design/sta_back.sv
// back part: record store, analysis sequencer and readout
module sta_back import sta_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [8:0] csr_data,
   input  logic       q_valid,
   output logic       q_take,
   input  cmd_type    q_cmd,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_column,
   output logic [5:0] rsp_row,
   output logic       rsp_last,
   output logic       rsp_status,
   output logic [8:0] rsp_min_centivolts,
   output logic [8:0] rsp_max_centivolts,
   output logic [5:0] rsp_trigger_offset,
   output logic       busy
);
   localparam logic [3:0] S_IDLE = 4'd0, S_PMM = 4'd1, S_PMW = 4'd2, S_SRC = 4'd3,
      S_SRW = 4'd4, S_WMM = 4'd5, S_WMW = 4'd6, S_CEN = 4'd7, S_RD = 4'd8,
      S_RW = 4'd9, S_MAP = 4'd10, S_DIV = 4'd11, S_OUT = 4'd12;

   // reciprocal of 255 scaled by 2^25, exact for dividends below 132626
   localparam logic [17:0] Div255Mul = 18'd131587;

   logic [7:0] store [StoreDepth];
   logic [7:0] rdata_ff;
   logic [AddrW-1:0] raddr;

   logic [3:0] st_ff, st_in;
   logic [1:0] mode_ff, gain_ff;
   logic [8:0] supply_ff;
   logic [7:0] fill_ff;
   logic       ready_ff;
   logic [7:0] ptr_ff;
   logic [7:0] lo_ff, hi_ff, prev_ff;
   logic [5:0] start_ff;
   logic [7:0] cen_ff;
   logic [6:0] ridx_ff;
   logic [8:0] lvl_ff;
   logic       found;
   logic [16:0] prod_ff;
   logic [8:0]  scl_ff;
   logic [13:0] drop_ff;

   logic       edge_md;
   logic [1:0] geff;
   logic [7:0] need;
   assign edge_md = (mode_ff == MODE_RISING) || (mode_ff == MODE_FALLING);
   assign geff    = (gain_ff == 2'd3) ? 2'd2 : gain_ff;
   assign need    = edge_md ? 8'(StoreDepth) : 8'(RecordLen);

   // divide by 255 through a constant multiply
   function automatic logic [8:0] div255(input logic [16:0] x);
      logic [34:0] p;
      p = {18'b0, x} * {17'b0, Div255Mul};
      return p[33:25];
   endfunction

   // read address per state
   always_comb begin
      if (st_ff == S_RD) raddr = AddrW'({2'b0, start_ff} + {1'b0, ridx_ff});
      else               raddr = AddrW'(ptr_ff);
   end

   // store: write from load, registered read
   always_ff @(posedge clock) begin
      if (q_take && q_cmd.kind == KIND_LOAD && !ready_ff && fill_ff < 8'(StoreDepth))
         store[AddrW'(fill_ff)] <= q_cmd.sample;
      rdata_ff <= store[raddr];
   end

   assign q_take = (st_ff == S_IDLE) && q_valid && !rsp_valid && !csr_write;
   assign busy   = (st_ff != S_IDLE);

   logic [7:0] span;
   logic [9:0] spr;
   logic [8:0] lvl_c;
   assign span  = hi_ff - lo_ff;
   assign spr   = {2'b0, span} << geff;
   assign lvl_c = {1'b0, lo_ff} + ((9'(hi_ff) - 9'(lo_ff) + 9'd1) >> 1);

   // crossing test on the pair held in prev and the read data
   always_comb begin
      found = 1'b0;
      if (ptr_ff != 8'd1) begin
         if (mode_ff == MODE_RISING)
            found = (9'(prev_ff) < lvl_ff) && (9'(rdata_ff) >= lvl_ff);
         else
            found = (9'(prev_ff) > lvl_ff) && (9'(rdata_ff) <= lvl_ff);
      end
   end

   // scaled point value before saturation
   logic [7:0]  diff;
   logic [10:0] scl_wide;
   assign diff     = rdata_ff - lo_ff;
   assign scl_wide = ({3'b0, diff} << geff) + {3'b0, cen_ff};

   // main sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; mode_ff <= MODE_RISING; gain_ff <= 2'd0;
         supply_ff <= 9'd500; fill_ff <= '0; ready_ff <= 1'b0; ridx_ff <= '0;
         rsp_valid <= 1'b0; start_ff <= '0; lo_ff <= '0; hi_ff <= '0; cen_ff <= '0;
      end else begin
         if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
         if (csr_write) begin
            unique case (csr_index)
               CSR_TRIGGER_MODE: begin
                  mode_ff <= csr_data[1:0]; fill_ff <= '0; ready_ff <= 1'b0;
                  ridx_ff <= '0;
               end
               CSR_GAIN_SHIFT: begin
                  gain_ff <= csr_data[1:0]; fill_ff <= '0; ready_ff <= 1'b0;
                  ridx_ff <= '0;
               end
               CSR_SUPPLY: supply_ff <= csr_data;
               default: ;
            endcase
         end else begin
            unique case (st_ff)
               S_IDLE: if (q_take) begin
                  if (q_cmd.kind == KIND_LOAD) begin
                     if (!ready_ff) begin
                        if (fill_ff < 8'(StoreDepth)) fill_ff <= fill_ff + 8'd1;
                        if (8'(fill_ff + 8'd1) >= need ||
                            (fill_ff >= 8'(StoreDepth) && fill_ff >= need)) begin
                           ptr_ff <= '0;
                           st_ff  <= edge_md ? S_PMM : S_WMM;
                           start_ff <= '0;
                        end
                     end
                  end else if (!ready_ff) begin
                     rsp_valid <= 1'b1; rsp_status <= 1'b1; rsp_column <= '0;
                     rsp_row <= '0; rsp_last <= 1'b0; rsp_min_centivolts <= '0;
                     rsp_max_centivolts <= '0; rsp_trigger_offset <= '0;
                  end else st_ff <= S_RD;
               end
               // pretrigger min/max: issue read then accumulate
               S_PMM: begin ptr_ff <= ptr_ff + 8'd1; st_ff <= S_PMW; end
               S_PMW: begin
                  if (ptr_ff == 8'd1) begin lo_ff <= rdata_ff; hi_ff <= rdata_ff; end
                  else begin
                     if (rdata_ff < lo_ff) lo_ff <= rdata_ff;
                     if (rdata_ff > hi_ff) hi_ff <= rdata_ff;
                  end
                  if (ptr_ff == 8'(PretrigLen)) begin ptr_ff <= '0; st_ff <= S_SRC; end
                  else st_ff <= S_PMM;
               end
               // crossing search over pairs
               S_SRC: begin
                  if (ptr_ff == 8'd0) lvl_ff <= lvl_c;
                  ptr_ff <= ptr_ff + 8'd1; st_ff <= S_SRW;
               end
               S_SRW: begin
                  prev_ff <= rdata_ff;
                  if (found) begin
                     start_ff <= 6'(ptr_ff - 8'd2);
                     ptr_ff <= 8'(ptr_ff - 8'd2); st_ff <= S_WMM;
                  end else if (ptr_ff == 8'(PretrigLen + 1)) begin
                     start_ff <= 6'(PretrigLen); ptr_ff <= 8'(PretrigLen); st_ff <= S_WMM;
                  end else st_ff <= S_SRC;
               end
               // window min/max
               S_WMM: begin ptr_ff <= ptr_ff + 8'd1; st_ff <= S_WMW; end
               S_WMW: begin
                  if (ptr_ff == 8'({2'b0, start_ff} + 8'd1)) begin
                     lo_ff <= rdata_ff; hi_ff <= rdata_ff;
                  end else begin
                     if (rdata_ff < lo_ff) lo_ff <= rdata_ff;
                     if (rdata_ff > hi_ff) hi_ff <= rdata_ff;
                  end
                  if (ptr_ff == 8'({2'b0, start_ff} + 8'(RecordLen))) st_ff <= S_CEN;
                  else st_ff <= S_WMM;
               end
               S_CEN: begin
                  cen_ff <= (spr >= 10'(FullScale)) ? 8'd0 :
                            8'((10'(FullScale) - spr) >> 1);
                  ready_ff <= 1'b1; ridx_ff <= '0; st_ff <= S_IDLE;
               end
               // readout
               S_RD: st_ff <= S_RW;
               S_RW: begin
                  scl_ff <= (scl_wide > 11'(FullScale)) ? 9'(FullScale) : scl_wide[8:0];
                  st_ff <= S_MAP;
               end
               S_MAP: begin
                  drop_ff <= {5'b0, scl_ff} * 14'(ChartRows);
                  prod_ff <= {9'b0, lo_ff} * {8'b0, supply_ff};
                  st_ff <= S_DIV;
               end
               S_DIV: begin
                  rsp_min_centivolts <= div255(prod_ff);
                  prod_ff <= {9'b0, hi_ff} * {8'b0, supply_ff};
                  drop_ff <= {5'b0, div255({3'b0, drop_ff})};
                  st_ff <= S_OUT;
               end
               S_OUT: begin
                  rsp_max_centivolts <= div255(prod_ff);
                  rsp_row <= (14'(ScreenRows - 1) >= drop_ff) ?
                             6'(14'(ScreenRows - 1) - drop_ff) : 6'd0;
                  rsp_column <= ridx_ff; rsp_status <= 1'b0;
                  rsp_last <= (ridx_ff == 7'(RecordLen - 1));
                  rsp_trigger_offset <= start_ff; rsp_valid <= 1'b1;
                  if (ridx_ff == 7'(RecordLen - 1)) begin
                     fill_ff <= '0; ready_ff <= 1'b0; ridx_ff <= '0;
                  end else ridx_ff <= ridx_ff + 7'd1;
                  st_ff <= S_IDLE;
               end
               default: st_ff <= S_IDLE;
            endcase
         end
      end
   end
endmodule

>>> design/scope_trigger_autoscale.sv
// top level of the scope trigger autoscale block
// Usage:
//  Requests arrive on req_valid/req_stall with req_kind and req_sample.
//  kind 0 loads one sample into the record store while it fills and gives
//  no response; kind 1 asks for the next display point and gives exactly
//  one response on rsp_valid/rsp_stall.
//  A request is written into the queue before the back part can take it.
//  A load is handled in the idle state; a readout of a ready record passes
//  through S_RD, S_RW, S_MAP, S_DIV and S_OUT before raising rsp_valid, and
//  the next request is taken only after that response is accepted.
//  When the record fills, an analysis sequencer scans the store through its
//  single read port: an edge record gets pretrigger min/max, a crossing
//  search and window min/max, a free running one only window min/max.
//  A two-entry queue sits between the request side and the back part, so
//  requests are taken while the back part works or a response waits.
//  Reset clears control state; the trigger mode returns to rising edge.
//  A stalled response holds; the back part takes no new request meanwhile.
//  The user writes configuration through csr_write/csr_index/csr_data only while idle; the block does not enforce it.
module scope_trigger_autoscale import sta_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [8:0] csr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_sample,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_column,
   output logic [5:0] rsp_row,
   output logic       rsp_last,
   output logic       rsp_status,
   output logic [8:0] rsp_min_centivolts,
   output logic [8:0] rsp_max_centivolts,
   output logic [5:0] rsp_trigger_offset
);
`include "scope_trigger_autoscale_assert.svh"
   cmd_type req_cmd, q_cmd;
   logic    q_valid, q_take, busy;

   assign req_cmd.kind   = req_kind;
   assign req_cmd.sample = req_sample;

   sta_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_cmd,
      .q_valid, .q_take, .q_cmd
   );

   sta_back u_back (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .q_valid, .q_take, .q_cmd,
      .rsp_valid, .rsp_stall, .rsp_column, .rsp_row, .rsp_last, .rsp_status,
      .rsp_min_centivolts, .rsp_max_centivolts, .rsp_trigger_offset, .busy
   );

   `STA_ASSERT(a_take_only_idle, q_take |-> !busy && q_valid)
   `STA_ASSERT(a_no_take_while_rsp, rsp_valid |-> !q_take)
   `STA_ASSERT_RST(a_rsp_clear_reset, reset |=> !rsp_valid)
endmodule

>>> bench/tb_scope_trigger_autoscale.sv
// self-checking bench for the scope trigger autoscale block
module tb_scope_trigger_autoscale;
   import sta_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic       KindRead   = 1'b1;
   localparam logic [1:0] ModeFree   = 2'd0;
   localparam int         SettleCyc  = 1000;
   localparam int         CycleLimit = 600000;

   typedef struct {
      logic       kind;
      logic [7:0] sample;
   } request_type;

   typedef struct {
      logic [6:0] column;
      logic [5:0] row;
      logic       last;
      logic       status;
      logic [8:0] min_cv;
      logic [8:0] max_cv;
      logic [5:0] offset;
   } point_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [8:0] csr_data = '0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_kind = 1'b0;
   logic [7:0] req_sample = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [6:0] rsp_column;
   logic [5:0] rsp_row;
   logic       rsp_last;
   logic       rsp_status;
   logic [8:0] rsp_min_centivolts;
   logic [8:0] rsp_max_centivolts;
   logic [5:0] rsp_trigger_offset;

   scope_trigger_autoscale dut (.*);

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   request_type pending_reqs[$];
   point_type   expected_points[$];
   int       mismatches = 0;
   int       idle_pct = 7;
   int       cycle_count = 0;

   // shadow state of the capture and scaling path
   logic [7:0] shadow_store[StoreDepth];
   int unsigned fill, win_start, win_min, win_max, center, read_idx;
   bit          ready;
   logic [1:0]  mode_reg = MODE_RISING;
   logic [1:0]  gain_reg = 2'd0;
   logic [8:0]  supply_reg = 9'd500;

   function automatic int unsigned gain_eff();
      return (gain_reg > 2) ? 2 : gain_reg;
   endfunction

   function automatic bit is_edge_mode();
      return mode_reg == MODE_RISING || mode_reg == MODE_FALLING;
   endfunction

   function automatic void restart_capture();
      fill = 0;
      ready = 0;
      read_idx = 0;
   endfunction

   function automatic void min_max(int unsigned from, int unsigned cnt,
                                   output int unsigned lo, output int unsigned hi);
      lo = shadow_store[from];
      hi = shadow_store[from];
      for (int i = 1; i < cnt; i++) begin
         if (shadow_store[from + i] < lo) lo = shadow_store[from + i];
         if (shadow_store[from + i] > hi) hi = shadow_store[from + i];
      end
   endfunction

   // trigger search and window scaling once the record is full
   function automatic void analyze_record();
      int unsigned lo, hi, level, a, b, spread;
      int unsigned start;
      start = 0;
      if (is_edge_mode()) begin
         min_max(0, PretrigLen, lo, hi);
         level = lo + ((hi - lo + 1) >> 1);
         while (start < PretrigLen) begin
            a = shadow_store[start];
            b = shadow_store[start + 1];
            if (mode_reg == MODE_RISING) begin
               if (a < level && b >= level) break;
            end else begin
               if (a > level && b <= level) break;
            end
            start++;
         end
      end
      min_max(start, RecordLen, lo, hi);
      win_start = start;
      win_min = lo;
      win_max = hi;
      spread = (hi - lo) << gain_eff();
      center = (spread >= FullScale) ? 0 : (FullScale - spread) >> 1;
      read_idx = 0;
      ready = 1;
   endfunction

   // apply one accepted request to the shadow state
   function automatic void predict_request(logic kind, logic [7:0] s);
      point_type p;
      int unsigned idx, scaled, drop;
      if (kind == KIND_LOAD) begin
         if (!ready) begin
            if (fill < StoreDepth) begin
               shadow_store[fill] = s;
               fill++;
            end
            if (fill >= (is_edge_mode() ? StoreDepth : RecordLen)) analyze_record();
         end
         return;
      end
      p = '{default: '0};
      if (!ready) begin
         p.status = 1'b1;
         expected_points.push_back(p);
         return;
      end
      idx = (read_idx < RecordLen) ? read_idx : RecordLen - 1;
      scaled = ((shadow_store[win_start + idx] - win_min) << gain_eff()) + center;
      if (scaled > FullScale) scaled = FullScale;
      drop = scaled * ChartRows / FullScale;
      p.column = idx[6:0];
      p.row = (ScreenRows - 1 >= drop) ? 6'(ScreenRows - 1 - drop) : 6'd0;
      p.last = (idx == RecordLen - 1);
      p.min_cv = 9'(win_min * supply_reg / FullScale);
      p.max_cv = 9'(win_max * supply_reg / FullScale);
      p.offset = win_start[5:0];
      expected_points.push_back(p);
      if (p.last) restart_capture();
      else read_idx = idx + 1;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %0s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      mismatches++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_request(req_kind, req_sample);
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_kind <= pending_reqs[0].kind;
               req_sample <= pending_reqs[0].sample;
               void'(pending_reqs.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      point_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            report_mismatch("unexpected point, column", rsp_column, -1);
         end else begin
            want = expected_points.pop_front();
            if (rsp_column !== want.column) report_mismatch("column", rsp_column, want.column);
            if (rsp_row !== want.row) report_mismatch("row", rsp_row, want.row);
            if (rsp_last !== want.last) report_mismatch("last", rsp_last, want.last);
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_min_centivolts !== want.min_cv)
               report_mismatch("min_centivolts", rsp_min_centivolts, want.min_cv);
            if (rsp_max_centivolts !== want.max_cv)
               report_mismatch("max_centivolts", rsp_max_centivolts, want.max_cv);
            if (rsp_trigger_offset !== want.offset)
               report_mismatch("trigger_offset", rsp_trigger_offset, want.offset);
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < idle_pct);
   end

   // run time guard
   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("tb_scope_trigger_autoscale: FAIL");
         $finish;
      end
   end

   task automatic push_request(logic kind, logic [7:0] s);
      request_type r;
      r.kind = kind;
      r.sample = s;
      pending_reqs.push_back(r);
   endtask

   // hold the sender until the block has drained and finished any analysis
   task automatic wait_idle(int extra);
      while (pending_reqs.size() != 0 || req_valid || expected_points.size() != 0)
         @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [8:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_TRIGGER_MODE) begin
         mode_reg = data[1:0];
         restart_capture();
      end else if (idx == CSR_GAIN_SHIFT) begin
         gain_reg = data[1:0];
         restart_capture();
      end else if (idx == CSR_SUPPLY) begin
         supply_reg = data;
      end
   endtask

   // waveform generator: noise, square, flat, or triangle
   function automatic logic [7:0] wave_point(int style, int i, int period, int lo, int hi);
      int ph;
      ph = i % period;
      unique case (style)
         0: return 8'($urandom_range(255));
         1: return 8'((ph < period / 2) ? lo : hi);
         2: return 8'(lo);
         default: return 8'(lo + (hi - lo) * ((ph < period / 2) ? ph : period - ph)
                            / (period / 2));
      endcase
   endfunction

   // loads for one record, with stray reads and ignored loads mixed in, then readout
   task automatic queue_record(int loads, int reads, int style);
      int period, lo, hi;
      period = $urandom_range(4, 70);
      lo = $urandom_range(0, 127);
      hi = $urandom_range(lo, 255);
      if ($urandom_range(3) == 0) begin
         lo = 0;
         hi = 255;
      end
      for (int i = 0; i < loads; i++) begin
         if ($urandom_range(99) < 3) push_request(KindRead, 8'($urandom));
         push_request(KIND_LOAD, wave_point(style, i, period, lo, hi));
      end
      for (int i = 0; i < reads; i++) begin
         if ($urandom_range(99) < 3) push_request(KIND_LOAD, 8'($urandom));
         push_request(KindRead, 8'($urandom));
      end
   endtask

   initial begin
      logic [1:0] modes[6];
      logic [1:0] gains[6];
      logic [8:0] supplies[6];
      int need;
      modes = '{MODE_RISING, ModeFree, MODE_FALLING, 2'd3, MODE_RISING, MODE_FALLING};
      gains = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0};
      supplies = '{9'd500, 9'd330, 9'd511, 9'd256, 9'd0, 9'd400};
      restart_capture();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reads before any record, loads at the sample extremes
      push_request(KindRead, 8'h00);
      push_request(KindRead, 8'hff);
      push_request(KIND_LOAD, 8'h00);
      push_request(KIND_LOAD, 8'hff);
      push_request(KindRead, 8'h00);
      wait_idle(SettleCyc);

      for (int r = 0; r < 6; r++) begin
         idle_pct = (r == 2) ? 0 : 7;
         write_csr(CSR_TRIGGER_MODE, {7'd0, modes[r]});
         write_csr(CSR_GAIN_SHIFT, {7'd0, gains[r]});
         write_csr(CSR_SUPPLY, supplies[r]);
         need = (modes[r] == MODE_RISING || modes[r] == MODE_FALLING) ? StoreDepth : RecordLen;
         // abort a partial record by a mode rewrite
         if (r == 4) begin
            queue_record(30, 0, 0);
            wait_idle(SettleCyc);
            write_csr(CSR_TRIGGER_MODE, {7'd0, modes[r]});
         end
         queue_record(need, RecordLen, r % 4);
         // broken readout: stop partway and restart through a gain write
         if (r == 1) begin
            queue_record(need, 30, 1);
            wait_idle(SettleCyc);
            write_csr(CSR_GAIN_SHIFT, {7'd0, gains[r]});
         end
         wait_idle(SettleCyc);
      end

      if (mismatches == 0) begin
         $display("tb_scope_trigger_autoscale: PASS");
      end else begin
         $display("tb_scope_trigger_autoscale: FAIL");
      end
      $finish;
   end
endmodule
